[src/omo_pkg.sv]
// ============================================================================
// Omni odometry motion sample - shared types, constants and stage logic
// Fixed-point constants, the pipeline payload and the per-stage datapath.
// ============================================================================
`default_nettype none

package omo_pkg;

   // Pipeline layout: stage numbers of each step
   localparam int unsigned ST_SQUARE = 0;
   localparam int unsigned ST_SUM    = 1;
   localparam int unsigned ST_PART   = 2;
   localparam int unsigned ST_COMB   = 3;
   localparam int unsigned ST_VAR    = 4;
   localparam int unsigned ST_SQRT0  = 5;
   localparam int unsigned SQRT_STEPS = 32;
   localparam int unsigned ATAN_STEPS = 30;
   localparam int unsigned ST_ATRND  = 35;
   localparam int unsigned ST_ATNRM  = 36;
   localparam int unsigned ST_DIFF   = 37;
   localparam int unsigned ST_BEAR   = 38;
   localparam int unsigned ST_BN0    = 39;
   localparam int unsigned ST_BN1    = 40;
   localparam int unsigned ST_BN2    = 41;
   localparam int unsigned ST_BN3    = 42;
   localparam int unsigned ST_SCPRE  = 43;
   localparam int unsigned ST_ROT0   = 44;
   localparam int unsigned ST_UNF    = 74;
   localparam int unsigned ST_MUL    = 75;
   localparam int unsigned ST_INC    = 76;
   localparam int unsigned ST_OUT    = 77;
   localparam int unsigned DEPTH     = 78;

   // Register map
   typedef enum logic [2:0] {
      REG_ROT_ROT      = 3'd0,
      REG_ROT_TRANS    = 3'd1,
      REG_TRANS_TRANS  = 3'd2,
      REG_ROT_OWN      = 3'd3,
      REG_STRAFE_TRANS = 3'd4
   } reg_index_type;

   localparam logic [23:0] GAIN_RESET = 24'd13107;

   // Angle constants (Q16.16 and Q30)
   localparam logic signed [33:0] PI_S       = 34'sd205887;
   localparam logic signed [33:0] TWO_PI_S   = 34'sd411775;
   localparam logic [19:0]        TWO_PI_U   = 20'd411775;
   localparam logic [18:0]        TWO_PI_Q16 = 19'd411775;
   localparam logic [13:0]        NORM_RECIP = 14'd10430;  // floor(2^16 / 2pi)
   localparam logic signed [35:0] PI_Q30_W   = 36'sd3373259426;
   localparam logic signed [33:0] PI_Q30     = 34'sd3373259426;
   localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [33:0] CORDIC_K   = 34'sd652032874;

   localparam logic [31:0] ATAN_TAB [ATAN_STEPS] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
      32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
   };

   typedef struct packed {
      logic [23:0] rot_rot;
      logic [23:0] rot_trans;
      logic [23:0] trans_trans;
      logic [23:0] rot_own;
      logic [23:0] strafe_trans;
   } gain_type;

   typedef struct packed {
      // item fields
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [31:0] dth;
      logic signed [31:0] head;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pth;
      logic signed [15:0] nt;
      logic signed [15:0] nr;
      logic signed [15:0] ns;
      // squares and variances
      logic [63:0]        sqdx;
      logic [63:0]        sqdy;
      logic [63:0]        sqr;
      logic [9:0][47:0]   pp;
      logic [4:0][63:0]   pv;
      logic [3:0][63:0]   rem;
      logic [3:0][31:0]   root;
      // atan2 vectoring
      logic signed [51:0] ax;
      logic signed [51:0] ay;
      logic signed [35:0] az;
      logic               azero;
      // angle normalisation
      logic signed [33:0] hd;
      logic               nneg;
      logic [31:0]        nabs;
      logic [13:0]        nq;
      logic [19:0]        nrem;
      logic signed [33:0] nhead;
      logic signed [33:0] na;
      logic signed [33:0] bear;
      logic signed [33:0] nb;
      // noisy motion
      logic signed [36:0] dev_t;
      logic signed [36:0] dev_r;
      logic signed [36:0] dev_s;
      logic signed [31:0] that;
      logic signed [31:0] rhat;
      logic signed [31:0] shat;
      // sine and cosine
      logic signed [33:0] cx;
      logic signed [33:0] cy;
      logic signed [33:0] cz;
      logic               cneg;
      logic signed [65:0] m_tc;
      logic signed [65:0] m_ss;
      logic signed [65:0] m_ts;
      logic signed [65:0] m_sc;
      logic signed [36:0] incx;
      logic signed [36:0] incy;
      // result
      logic [31:0]        newx;
      logic [31:0]        newy;
      logic [31:0]        newth;
   } pipe_type;

   function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [38:0] v);
      logic signed [31:0] r;
      if (v > 39'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -39'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Finish a remainder on 2pi: correct once, apply sign, fold into (-pi, pi]
   function automatic logic signed [33:0] norm_fin(input logic neg, input logic [19:0] rem);
      logic [19:0]        r;
      logic signed [33:0] rs;
      r = (rem >= TWO_PI_U) ? rem - TWO_PI_U : rem;
      rs = {14'b0, r};
      if (neg) begin
         rs = -rs;
      end
      if (rs < 0) begin
         rs = rs + TWO_PI_S;
      end
      if (rs > PI_S) begin
         rs = rs - TWO_PI_S;
      end
      return rs;
   endfunction

   // Fold an angle known to lie within two turns into (-pi, pi]
   function automatic logic signed [33:0] norm_small(input logic signed [33:0] a);
      logic signed [33:0] r;
      r = a;
      if (a >= TWO_PI_S) begin
         r = a - TWO_PI_S;
      end else if (a <= -TWO_PI_S) begin
         r = a + TWO_PI_S;
      end
      if (r < 0) begin
         r = r + TWO_PI_S;
      end
      if (r > PI_S) begin
         r = r - TWO_PI_S;
      end
      return r;
   endfunction

   // Logic of one pipeline stage; idx is fixed for each instance
   function automatic pipe_type stage_fn(input int unsigned idx, input pipe_type p,
                                         input gain_type g);
      pipe_type           q;
      logic [47:0]        at;
      logic [47:0]        ar;
      logic [71:0]        pr;
      logic [65:0]        trial;
      logic [45:0]        rp;
      logic [31:0]        qd;
      logic signed [51:0] xs;
      logic signed [51:0] ys;
      logic signed [35:0] zt;
      logic signed [33:0] d1;
      logic signed [33:0] d2;
      logic signed [33:0] a1;
      logic signed [33:0] a2;
      logic signed [33:0] cxs;
      logic signed [33:0] cys;
      logic signed [33:0] src;
      logic signed [48:0] mp;
      logic signed [38:0] hs;
      logic signed [66:0] acc;
      int unsigned        k;
      int unsigned        i;
      q = p;

      // Squares, atan2 quadrant fold, old heading
      if (idx == ST_SQUARE) begin
         q.sqdx = p.dx * p.dx;
         q.sqdy = p.dy * p.dy;
         q.sqr  = p.dth * p.dth;
         q.azero = (p.dx == '0) && (p.dy == '0);
         xs = {{4{p.dx[31]}}, p.dx, 16'h0000};
         ys = {{4{p.dy[31]}}, p.dy, 16'h0000};
         if (p.dx[31]) begin
            q.ax = -xs;
            q.ay = -ys;
            q.az = p.dy[31] ? -PI_Q30_W : PI_Q30_W;
         end else begin
            q.ax = xs;
            q.ay = ys;
            q.az = '0;
         end
         q.hd = {{2{p.head[31]}}, p.head} - {{2{p.dth[31]}}, p.dth};
      end

      if (idx == ST_SUM) begin
         q.sqdx = p.sqdx + p.sqdy;
      end

      // Magnitude and sign of the angle to normalise
      if (idx == ST_SUM || idx == ST_BN0) begin
         src = (idx == ST_SUM) ? p.hd : p.bear;
         q.nneg = src[33];
         q.nabs = src[33] ? 32'(-src) : src[31:0];
      end

      // Quotient estimate by reciprocal
      if (idx == ST_PART || idx == ST_BN1) begin
         rp = p.nabs * NORM_RECIP;
         q.nq = rp[45:32];
      end

      // Remainder estimate, below twice 2pi
      if (idx == ST_COMB || idx == ST_BN2) begin
         qd = p.nq * TWO_PI_Q16;
         q.nrem = 20'(p.nabs - qd);
      end

      // Gain partial products, 24 by 24
      if (idx == ST_PART) begin
         at = p.sqdx[63:16];
         ar = p.sqr[63:16];
         q.pp[0] = g.rot_rot * ar[23:0];
         q.pp[1] = g.rot_rot * ar[47:24];
         q.pp[2] = g.rot_trans * at[23:0];
         q.pp[3] = g.rot_trans * at[47:24];
         q.pp[4] = g.trans_trans * at[23:0];
         q.pp[5] = g.trans_trans * at[47:24];
         q.pp[6] = g.rot_own * ar[23:0];
         q.pp[7] = g.rot_own * ar[47:24];
         q.pp[8] = g.strafe_trans * at[23:0];
         q.pp[9] = g.strafe_trans * at[47:24];
      end

      // Combine partial products, saturate at 64 bits
      if (idx == ST_COMB) begin
         for (int unsigned u = 0; u < 5; u++) begin
            pr = {24'h000000, p.pp[2*u]} + {p.pp[2*u+1], 24'h000000};
            q.pv[u] = (pr[71:64] != '0) ? '1 : pr[63:0];
         end
      end

      // Variances and square root set-up
      if (idx == ST_VAR) begin
         q.rem[0] = sat_add64(p.pv[2], p.pv[0]);
         q.rem[1] = sat_add64(p.pv[3], p.pv[1]);
         q.rem[2] = sat_add64(p.pv[0], p.pv[4]);
         q.rem[3] = p.sqdx;
         q.root = '0;
      end

      if (idx == ST_VAR || idx == ST_BN3) begin
         if (idx == ST_VAR) begin
            q.nhead = norm_fin(p.nneg, p.nrem);
         end else begin
            q.nb = norm_fin(p.nneg, p.nrem);
         end
      end

      // One root bit per stage for all four square roots
      if (idx >= ST_SQRT0 && idx < ST_SQRT0 + SQRT_STEPS) begin
         k = SQRT_STEPS - 1 - (idx - ST_SQRT0);
         for (int unsigned u = 0; u < 4; u++) begin
            trial = ({34'b0, p.root[u]} << (k + 1)) + (66'(1) << (2 * k));
            if ({2'b00, p.rem[u]} >= trial) begin
               q.rem[u] = 64'({2'b00, p.rem[u]} - trial);
               q.root[u] = p.root[u] | (32'(1) << k);
            end
         end
      end

      // Vectoring step of atan2
      if (idx >= ST_SQRT0 && idx < ST_SQRT0 + ATAN_STEPS) begin
         i = idx - ST_SQRT0;
         xs = p.ax;
         ys = p.ay;
         if (ys > 0) begin
            q.ax = xs + (ys >>> i);
            q.ay = ys - (xs >>> i);
            q.az = p.az + $signed({4'b0, ATAN_TAB[i]});
         end else begin
            q.ax = xs - (ys >>> i);
            q.ay = ys + (xs >>> i);
            q.az = p.az - $signed({4'b0, ATAN_TAB[i]});
         end
      end

      // Round the bearing to Q16.16
      if (idx == ST_ATRND) begin
         zt = (p.az + 36'sd8192) >>> 14;
         q.na = p.azero ? '0 : 34'(zt);
      end

      if (idx == ST_ATNRM) begin
         q.na = norm_small(p.na);
      end

      // Shortest angle difference, deviations
      if (idx == ST_DIFF) begin
         d1 = p.na - p.nhead;
         a1 = (d1 < 0) ? -d1 : d1;
         d2 = TWO_PI_S - a1;
         if (d1 > 0) begin
            d2 = -d2;
         end
         a2 = (d2 < 0) ? -d2 : d2;
         q.bear = (a1 < a2) ? d1 : d2;
         mp = $signed({1'b0, p.root[0]}) * p.nt;
         q.dev_t = 37'(mp >>> 12);
         mp = $signed({1'b0, p.root[1]}) * p.nr;
         q.dev_r = 37'(mp >>> 12);
         mp = $signed({1'b0, p.root[2]}) * p.ns;
         q.dev_s = 37'(mp >>> 12);
      end

      // Bearing and saturated noisy motion
      if (idx == ST_BEAR) begin
         q.bear = p.bear + {{2{p.pth[31]}}, p.pth};
         hs = $signed({7'b0, p.root[3]}) + 39'(p.dev_t);
         q.that = sat32(hs);
         hs = 39'(p.dth) + 39'(p.dev_r);
         q.rhat = sat32(hs);
         hs = 39'(p.dev_s);
         q.shat = sat32(hs);
      end

      // Fold into the right half plane for rotation
      if (idx == ST_SCPRE) begin
         a1 = 34'(p.nb <<< 14);
         q.cneg = 1'b0;
         if (a1 > HALF_PI_Q30) begin
            a1 = a1 - PI_Q30;
            q.cneg = 1'b1;
         end else if (a1 < -HALF_PI_Q30) begin
            a1 = a1 + PI_Q30;
            q.cneg = 1'b1;
         end
         q.cz = a1;
         q.cx = CORDIC_K;
         q.cy = '0;
      end

      // Rotation step of sine and cosine
      if (idx >= ST_ROT0 && idx < ST_ROT0 + ATAN_STEPS) begin
         i = idx - ST_ROT0;
         cxs = p.cx;
         cys = p.cy;
         if (p.cz >= 0) begin
            q.cx = cxs - (cys >>> i);
            q.cy = cys + (cxs >>> i);
            q.cz = p.cz - $signed({2'b0, ATAN_TAB[i]});
         end else begin
            q.cx = cxs + (cys >>> i);
            q.cy = cys - (cxs >>> i);
            q.cz = p.cz + $signed({2'b0, ATAN_TAB[i]});
         end
      end

      if (idx == ST_UNF && p.cneg) begin
         q.cx = -p.cx;
         q.cy = -p.cy;
      end

      if (idx == ST_MUL) begin
         q.m_tc = p.that * p.cx;
         q.m_ss = p.shat * p.cy;
         q.m_ts = p.that * p.cy;
         q.m_sc = p.shat * p.cx;
      end

      if (idx == ST_INC) begin
         acc = 67'(p.m_tc) + 67'(p.m_ss);
         q.incx = 37'(acc >>> 30);
         acc = 67'(p.m_ts) - 67'(p.m_sc);
         q.incy = 37'(acc >>> 30);
      end

      // New pose, wrapped to 32 bits
      if (idx == ST_OUT) begin
         q.newx  = p.px + p.incx[31:0];
         q.newy  = p.py + p.incy[31:0];
         q.newth = p.pth + p.rhat;
      end
      return q;
   endfunction

endpackage

`default_nettype wire

[src/omni_odometry_motion_sample.sv]
// ============================================================================
// Omni odometry motion sample - top level
// Moves one particle pose per item by the omnidirectional odometry motion
// model with externally supplied unit normal noise samples.
// ============================================================================
//
//   channel  direction  handshake             payload
//   req_     in         req_tvalid/tready     odometry delta, heading, pose, noise
//   rsp_     out        rsp_tvalid/tready     new pose
//   csr_     in         csr_we                five Q8.16 gains
//
// One item per cycle while results are taken; each item passes 78 register stages
// before its result is offered.
// The depth is set by the 32-step square root (the 30-step atan2 runs beside
// it) followed by the 30-step sine and cosine chain, each step a stage.
// A held result freezes the whole pipeline; nothing is lost or repeated.
// Reset clears the valid bits and loads every gain with 0.2; no clearing pass.
`default_nettype none

module omni_odometry_motion_sample (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // odom_dx, odom_dy, odom_dtheta, odom_heading, particle_x, particle_y,
   // particle_theta (32 each), noise_trans, noise_rot, noise_strafe (16 each)
   input  wire logic [271:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // new_x, new_y, new_theta (32 each)
   output logic [95:0]       rsp_tdata,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_addr,
   input  wire logic [23:0]  csr_wdata
);

   localparam int unsigned DEPTH = omo_pkg::DEPTH;

   omo_pkg::gain_type gain_ff;
   omo_pkg::pipe_type in_pkt;
   omo_pkg::pipe_type pl_ff [DEPTH];
   omo_pkg::pipe_type pl_in [DEPTH];
   logic [DEPTH-1:0]  vd_ff;
   logic              adv;

   // Advance while the output stage is empty or being taken
   assign adv        = !vd_ff[DEPTH-1] || rsp_tready;
   assign req_tready = adv;

   // Gain registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff.rot_rot      <= omo_pkg::GAIN_RESET;
         gain_ff.rot_trans    <= omo_pkg::GAIN_RESET;
         gain_ff.trans_trans  <= omo_pkg::GAIN_RESET;
         gain_ff.rot_own      <= omo_pkg::GAIN_RESET;
         gain_ff.strafe_trans <= omo_pkg::GAIN_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            omo_pkg::REG_ROT_ROT:      gain_ff.rot_rot      <= csr_wdata;
            omo_pkg::REG_ROT_TRANS:    gain_ff.rot_trans    <= csr_wdata;
            omo_pkg::REG_TRANS_TRANS:  gain_ff.trans_trans  <= csr_wdata;
            omo_pkg::REG_ROT_OWN:      gain_ff.rot_own      <= csr_wdata;
            omo_pkg::REG_STRAFE_TRANS: gain_ff.strafe_trans <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Unpack the incoming item
   always_comb begin
      in_pkt      = '0;
      in_pkt.dx   = req_tdata[31:0];
      in_pkt.dy   = req_tdata[63:32];
      in_pkt.dth  = req_tdata[95:64];
      in_pkt.head = req_tdata[127:96];
      in_pkt.px   = req_tdata[159:128];
      in_pkt.py   = req_tdata[191:160];
      in_pkt.pth  = req_tdata[223:192];
      in_pkt.nt   = req_tdata[239:224];
      in_pkt.nr   = req_tdata[255:240];
      in_pkt.ns   = req_tdata[271:256];
   end

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= '0;
      end else if (adv) begin
         vd_ff <= {vd_ff[DEPTH-2:0], req_tvalid};
      end
   end

   // Pipeline stages
   for (genvar s = 0; s < DEPTH; s++) begin : g_stage
      if (s == 0) begin : g_head
         always_comb begin
            pl_in[s] = omo_pkg::stage_fn(s, in_pkt, gain_ff);
         end
      end else begin : g_body
         always_comb begin
            pl_in[s] = omo_pkg::stage_fn(s, pl_ff[s-1], gain_ff);
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            pl_ff[s] <= pl_in[s];
         end
      end
   end

   // Result
   assign rsp_tvalid = vd_ff[DEPTH-1];
   assign rsp_tdata  = {pl_ff[DEPTH-1].newth, pl_ff[DEPTH-1].newy, pl_ff[DEPTH-1].newx};

endmodule

`default_nettype wire

[bench/omni_odometry_motion_sample_test.sv]
// ============================================================================
// Omni odometry motion sample - testbench
// Streams particle items through the block under several gain settings,
// predicts each new pose in the bench and checks every result item in order.
// ============================================================================
`timescale 1ns / 1ps

module omni_odometry_motion_sample_test;

   typedef struct {
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [31:0] dth;
      logic signed [31:0] head;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pth;
      logic signed [15:0] nt;
      logic signed [15:0] nr;
      logic signed [15:0] ns;
   } motion_item_type;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] th;
   } pose_type;

   typedef struct {
      motion_item_type it;
      bit              typed;
      pose_type        pose;
   } dir_row_type;

   localparam longint PI_Q16      = 205887;
   localparam longint TWO_PI_Q16L = 411775;
   localparam longint PI_W        = 64'sd3373259426;
   localparam longint HALF_PI_W   = 64'sd1686629713;
   localparam longint GAIN_K      = 64'sd652032874;
   localparam int     DRAIN_WAIT  = 90;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [271:0]  req_tdata;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [95:0]   rsp_tdata;
   logic          csr_we;
   logic [2:0]    csr_addr;
   logic [23:0]   csr_wdata;

   logic [23:0]   gain [5];
   pose_type      pending_poses [$];
   int            fail_count;
   int            result_count;
   dir_row_type   dir_tab [16];

   omni_odometry_motion_sample dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Time limit
   initial begin
      #8000000;
      $display("omni_odometry_motion_sample: mismatch");
      $finish;
   end

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Root of a saturating gain-weighted sum of two squares
   function automatic longint unsigned gain_root(logic [23:0] ga, longint unsigned sqa,
                                                 logic [23:0] gb, longint unsigned sqb);
      logic [127:0] pa;
      logic [127:0] pb;
      logic [64:0]  s;
      pa = 128'(ga) * 128'(sqa >> 16);
      pb = 128'(gb) * 128'(sqb >> 16);
      if (pa[127:64] != 0) pa = 128'({64{1'b1}});
      if (pb[127:64] != 0) pb = 128'({64{1'b1}});
      s = {1'b0, pa[63:0]} + {1'b0, pb[63:0]};
      if (s[64]) s = {1'b0, {64{1'b1}}};
      return int_sqrt(s[63:0]);
   endfunction

   function automatic longint noise_dev(longint unsigned sd, logic signed [15:0] n);
      return (longint'(sd) * longint'(n)) >>> 12;
   endfunction

   function automatic longint sat_word(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint wrap_angle(longint a);
      longint r;
      r = a % TWO_PI_Q16L;
      if (r < 0) r = r + TWO_PI_Q16L;
      if (r > PI_Q16) r = r - TWO_PI_Q16L;
      return r;
   endfunction

   // Expected new pose of one particle under the current gains
   function automatic pose_type predict_pose(motion_item_type it);
      longint          dx, dy, dth, x, y, z, nx, ny, d1, d2, a1, a2;
      longint          ang, t_hat, r_hat, s_hat, bearing, sn, cs;
      longint unsigned sq_t, sq_r, sd_t, sd_r, sd_s;
      bit              neg;
      pose_type        r;
      dx = it.dx;
      dy = it.dy;
      dth = it.dth;
      sq_t = longint'(dx * dx) + longint'(dy * dy);
      sq_r = dth * dth;
      sd_t = gain_root(gain[omo_pkg::REG_TRANS_TRANS], sq_t, gain[omo_pkg::REG_ROT_ROT], sq_r);
      sd_r = gain_root(gain[omo_pkg::REG_ROT_OWN], sq_r, gain[omo_pkg::REG_ROT_TRANS], sq_t);
      sd_s = gain_root(gain[omo_pkg::REG_ROT_ROT], sq_r, gain[omo_pkg::REG_STRAFE_TRANS],
                       sq_t);
      t_hat = sat_word(longint'(int_sqrt(sq_t)) + noise_dev(sd_t, it.nt));
      r_hat = sat_word(dth + noise_dev(sd_r, it.nr));
      s_hat = sat_word(noise_dev(sd_s, it.ns));

      // Bearing of the delta by vectoring; a zero delta points nowhere
      ang = 0;
      if (dx != 0 || dy != 0) begin
         x = dx * 65536;
         y = dy * 65536;
         z = 0;
         if (x < 0) begin
            z = (y >= 0) ? PI_W : -PI_W;
            x = -x;
            y = -y;
         end
         for (int i = 0; i < omo_pkg::ATAN_STEPS; i++) begin
            if (y > 0) begin
               nx = x + (y >>> i); ny = y - (x >>> i);
               z = z + longint'(omo_pkg::ATAN_TAB[i]);
            end else begin
               nx = x - (y >>> i); ny = y + (x >>> i);
               z = z - longint'(omo_pkg::ATAN_TAB[i]);
            end
            x = nx;
            y = ny;
         end
         ang = (z + 8192) >>> 14;
      end

      // Shortest difference to the old odometry heading
      d1 = wrap_angle(ang) - wrap_angle(longint'(it.head) - dth);
      a1 = (d1 < 0) ? -d1 : d1;
      d2 = TWO_PI_Q16L - a1;
      if (d1 > 0) d2 = -d2;
      a2 = (d2 < 0) ? -d2 : d2;
      bearing = ((a1 < a2) ? d1 : d2) + longint'(it.pth);

      // Sine and cosine by rotation, folded into the right half plane
      z = wrap_angle(bearing) * 16384;
      x = GAIN_K;
      y = 0;
      neg = 0;
      if (z > HALF_PI_W) begin
         z = z - PI_W; neg = 1;
      end else if (z < -HALF_PI_W) begin
         z = z + PI_W; neg = 1;
      end
      for (int i = 0; i < omo_pkg::ATAN_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i); ny = y + (x >>> i);
            z = z - longint'(omo_pkg::ATAN_TAB[i]);
         end else begin
            nx = x + (y >>> i); ny = y - (x >>> i);
            z = z + longint'(omo_pkg::ATAN_TAB[i]);
         end
         x = nx;
         y = ny;
      end
      cs = neg ? -x : x;
      sn = neg ? -y : y;

      r.x  = 32'(longint'(it.px) + ((t_hat * cs + s_hat * sn) >>> 30));
      r.y  = 32'(longint'(it.py) + ((t_hat * sn - s_hat * cs) >>> 30));
      r.th = 32'(longint'(it.pth) + r_hat);
      return r;
   endfunction

   function automatic motion_item_type mk_item(logic [31:0] dx, logic [31:0] dy,
                                               logic [31:0] dth, logic [31:0] head,
                                               logic [31:0] px, logic [31:0] py,
                                               logic [31:0] pth, logic [15:0] nt,
                                               logic [15:0] nr, logic [15:0] ns);
      motion_item_type m;
      m.dx = dx; m.dy = dy; m.dth = dth; m.head = head;
      m.px = px; m.py = py; m.pth = pth;
      m.nt = nt; m.nr = nr; m.ns = ns;
      return m;
   endfunction

   function automatic dir_row_type mk_row(motion_item_type it, bit typed);
      dir_row_type d;
      d.it = it;
      d.typed = typed;
      // With no motion every deviation is zero and the pose is unchanged
      d.pose.x = it.px;
      d.pose.y = it.py;
      d.pose.th = it.pth;
      return d;
   endfunction

   // Mostly plausible magnitudes, some full-range words and extremes
   function automatic logic [31:0] rand_word(int span);
      logic [31:0] v;
      case ($urandom_range(0, 7))
         0: v = $urandom;
         1: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2: v = 0;
         default: v = 32'($signed($urandom_range(0, 2 * span)) - span);
      endcase
      return v;
   endfunction

   function automatic logic [15:0] rand_noise();
      logic [15:0] v;
      case ($urandom_range(0, 9))
         0: v = 16'($urandom);
         1: v = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         default: v = 16'($signed($urandom_range(0, 24576)) - 12288);
      endcase
      return v;
   endfunction

   function automatic motion_item_type rand_item();
      return mk_item(rand_word(65536), rand_word(65536), rand_word(80000),
                     rand_word(1000000), rand_word(20000000), rand_word(20000000),
                     rand_word(1000000), rand_noise(), rand_noise(), rand_noise());
   endfunction

   // Offer one item after a gap; called and returns at a falling edge
   task automatic offer_item(motion_item_type it, int gap, bit typed, pose_type typed_pose);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {it.ns, it.nr, it.nt, it.pth, it.py, it.px, it.head, it.dth, it.dy, it.dx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_poses.push_back(typed ? typed_pose : predict_pose(it));
      @(negedge clock);
   endtask

   // Hold input until every result is back and the pipeline has emptied
   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (pending_poses.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   // Write one register; the caller drops the enable after the last write
   task automatic write_gain(logic [2:0] idx, logic [23:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      if (idx <= 3'(omo_pkg::REG_STRAFE_TRANS)) gain[idx] = val;
      @(negedge clock);
   endtask

   // Result side: random stall per item outside stretches with none, one long hold-off
   initial begin
      int       stall;
      pose_type got;
      pose_type want;
      rsp_tready = 1'b0;
      result_count = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = ((result_count / 50) % 3 == 1) ? 0 : $urandom_range(0, 9);
         if (result_count == 500) stall = 1200;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         got.x = rsp_tdata[31:0];
         got.y = rsp_tdata[63:32];
         got.th = rsp_tdata[95:64];
         result_count++;
         if (pending_poses.size() == 0) begin
            $error("unexpected result item %h", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_poses.pop_front();
            if (got.x !== want.x) begin
               $error("new_x: expected %h, got %h", want.x, got.x);
               fail_count++;
            end
            if (got.y !== want.y) begin
               $error("new_y: expected %h, got %h", want.y, got.y);
               fail_count++;
            end
            if (got.th !== want.th) begin
               $error("new_theta: expected %h, got %h", want.th, got.th);
               fail_count++;
            end
         end
         @(negedge clock);
      end
   end

   // Main sequence
   initial begin
      logic [23:0] setting;
      pose_type    none;
      fail_count = 0;
      none = '{default: 0};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      for (int g = 0; g < 5; g++) gain[g] = omo_pkg::GAIN_RESET;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: zero motion at extreme poses, extreme deltas and noise
      dir_tab[0]  = mk_row(mk_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1);
      dir_tab[1]  = mk_row(mk_item(0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                   32'h7FFFFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF), 1);
      dir_tab[2]  = mk_row(mk_item(0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000,
                                   32'h80000000, 16'h8000, 16'h8000, 16'h8000), 1);
      dir_tab[3]  = mk_row(mk_item(32'h7FFFFFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
      dir_tab[4]  = mk_row(mk_item(32'h80000000, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
      dir_tab[5]  = mk_row(mk_item(0, 32'h80000000, 0, 0, 0, 0, 0, 0, 0, 0), 0);
      // Delta along negative x only: bearing of plus pi
      dir_tab[6]  = mk_row(mk_item(-65536, 0, 0, 0, 1000, 2000, 3000, 0, 0, 0), 0);
      dir_tab[7]  = mk_row(mk_item(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                                   32'h80000000, 32'h80000000, 32'h80000000, 16'h8000,
                                   16'h8000, 16'h8000), 0);
      dir_tab[8]  = mk_row(mk_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                   32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h7FFF,
                                   16'h7FFF, 16'h7FFF), 0);
      dir_tab[9]  = mk_row(mk_item(65536, 65536, 6554, 102943, 0, 0, 0, 4096, -4096, 4096), 0);
      dir_tab[10] = mk_row(mk_item(0, 0, 32'h7FFFFFFF, 0, 0, 0, 0, 16'h7FFF, 16'h7FFF,
                                   16'h8000), 0);
      dir_tab[11] = mk_row(mk_item(0, 0, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 16'h8000,
                                   16'h8000, 16'h7FFF), 0);
      dir_tab[12] = mk_row(mk_item(-6554, 13107, -3277, -205887, 500000, -500000, 205887,
                                   -8192, 8192, 12288), 0);
      dir_tab[13] = mk_row(mk_item(0, 65536, 0, 205887, 0, 0, 0, 0, 0, 0), 0);
      dir_tab[14] = mk_row(mk_item(0, -65536, 0, -205887, 0, 0, 32'h7FFFFFFF, 0, 0, 0), 0);
      dir_tab[15] = mk_row(mk_item(1, -1, 1, 0, 0, 0, 0, 16'h0001, 16'hFFFF, 16'h0001), 0);
      foreach (dir_tab[r])
         offer_item(dir_tab[r].it, $urandom_range(0, 3), dir_tab[r].typed, dir_tab[r].pose);
      drain_block();

      // Random items under the reset gains, both extremes, the reset gains again and random gains
      for (int phase = 0; phase < 6; phase++) begin
         if (phase > 0) begin
            for (int g = 0; g < 5; g++) begin
               case (phase)
                  1: setting = 24'h000000;
                  2: setting = 24'hFFFFFF;
                  3: setting = omo_pkg::GAIN_RESET;
                  default: setting = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                                : 24'($urandom_range(0, 65536));
               endcase
               write_gain(3'(g), setting);
            end
            // Spare indexes must be ignored
            write_gain(3'($urandom_range(5, 7)), 24'($urandom));
            csr_we <= 1'b0;
         end
         for (int n = 0; n < 285; n++)
            offer_item(rand_item(), ((n / 40) % 4 == 2) ? 0 : $urandom_range(0, 9), 0, none);
         drain_block();
      end

      if (fail_count == 0) begin
         $display("omni_odometry_motion_sample: match");
      end else begin
         $display("omni_odometry_motion_sample: mismatch");
      end
      $finish;
   end

endmodule
